// ----- src/gtse_pkg.sv -----
// ----------------------------------------------------------------------------
// gtse_pkg
// shared types and constants for the grid triplet structure energy block
// ----------------------------------------------------------------------------
`default_nettype none

package gtse_pkg;

    localparam int RATIO_W  = 24;
    localparam int ENERGY_W = 34;
    localparam int OUT_E_W  = 35;
    localparam int NUM2_W   = 44;
    localparam int DEN2_W   = 41;
    localparam int QUO_W    = 48;
    localparam int ONE_Q16  = 65536;

    typedef enum logic [1:0] {
        F_LOAD_CORNER = 2'd0,
        F_LOAD_CELL   = 2'd1,
        F_COMPUTE     = 2'd2,
        F_READ        = 2'd3
    } t_func;

    localparam logic [1:0] CFG_ROWS   = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_WEIGHT = 2'd2;

    localparam logic [1:0] DIR_ROW  = 2'd0;
    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_COL  = 2'd2;

    localparam logic KIND_BEST   = 1'b0;
    localparam logic KIND_ENERGY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       ld_corner;
        logic       ld_cell;
        logic       rd_energy;
        logic       best_clr;
        logic       g_rd;
        logic       cell_cap;
        logic       p_rd;
        logic       pt_cap;
        logic [1:0] cap_sel;
        logic [1:0] rd_sel;
        logic       diff;
        logic       square;
        logic       sum;
        logic       ratio_go;
        logic       mul;
        logic       wr;
        logic       clr_wr;
        logic       emit;
        logic       emit_kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic filled;
        logic ratio_done;
    } t_sts;

endpackage

`default_nettype wire

// ----- src/grid_triplet_structure_energy.sv -----
// ----------------------------------------------------------------------------
// grid_triplet_structure_energy
// structure energy of a grid of corner points over row, diagonal and column
// triples, with corner table and grid loads and energy readback
// ----------------------------------------------------------------------------
// load items are written as they are accepted; a read registers the energy store
// value, waits until the output register is free, loads it and then takes the next item
// a compute scans 3*MAX_ROWS*MAX_COLS positions, skipping one out of range or with
// an empty cell and passing a filled triple through the ratio unit (48 division and
// 24 square root steps, skipped when the ratio saturates), then emits the best result
// a result waits in the output register while further loads are accepted
// after reset the energy store is cleared address by address before input is taken
`default_nettype none

module grid_triplet_structure_energy #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLS    = 16,
    parameter int MAX_CORNERS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // corner_slot, point_x, point_y, cell_row, cell_col, cell_corner, read_direction
    input  wire logic [71:0] s_axis_tdata,
    // func
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // best_col, best_row, best_direction, energy_value
    output logic [47:0]      m_axis_tdata,
    // result_kind
    output logic [0:0]       m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);
    import gtse_pkg::*;

    localparam int GRID_AW = $clog2(MAX_ROWS * MAX_COLS);

    logic [4:0]          r_grid_rows, r_grid_cols;
    logic [8:0]          r_weight;
    logic                r_m_valid;
    logic [47:0]         r_m_data;
    logic                r_m_kind;

    t_cmd                w_cmd;
    t_sts                w_sts;
    logic [GRID_AW-1:0]  w_grid_addr;
    logic [$clog2(MAX_ROWS)-1:0] w_walk_row;
    logic [$clog2(MAX_COLS)-1:0] w_walk_col;
    logic [1:0]          w_walk_dir;
    logic                w_out_free;
    logic [3:0]          w_best_col, w_best_row;
    logic [1:0]          w_best_dir;
    logic [OUT_E_W-1:0]  w_energy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= 5'd16;
            r_grid_cols <= 5'd16;
            r_weight    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS:   r_grid_rows <= i_cfg_data[4:0];
                CFG_COLS:   r_grid_cols <= i_cfg_data[4:0];
                CFG_WEIGHT: r_weight    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_m_kind <= w_cmd.emit_kind;
            if (w_cmd.emit_kind == KIND_BEST) begin
                r_m_data <= {3'b0, {OUT_E_W{1'b0}}, w_best_dir, w_best_row, w_best_col};
            end else begin
                r_m_data <= {3'b0, w_energy, 10'b0};
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

    gtse_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_func   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_free  (w_out_free),
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_grid_addr (w_grid_addr),
        .o_walk_row  (w_walk_row),
        .o_walk_col  (w_walk_col),
        .o_walk_dir  (w_walk_dir)
    );

    gtse_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_CORNERS (MAX_CORNERS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_grid_addr      (w_grid_addr),
        .i_walk_row       (w_walk_row),
        .i_walk_col       (w_walk_col),
        .i_walk_dir       (w_walk_dir),
        .i_weight         (r_weight),
        .i_corner_slot    (s_axis_tdata[7:0]),
        .i_point_x        (s_axis_tdata[27:8]),
        .i_point_y        (s_axis_tdata[47:28]),
        .i_cell_row       (s_axis_tdata[51:48]),
        .i_cell_col       (s_axis_tdata[55:52]),
        .i_cell_corner    (s_axis_tdata[64:56]),
        .i_read_direction (s_axis_tdata[66:65]),
        .o_best_col       (w_best_col),
        .o_best_row       (w_best_row),
        .o_best_direction (w_best_dir),
        .o_energy_value   (w_energy)
    );

endmodule

`default_nettype wire

// ----- src/gtse_ratio.sv -----
// ----------------------------------------------------------------------------
// gtse_ratio
// ratio unit: floor(2^16 * sqrt(num2 / den2)) saturating at 24 bits,
// restoring division then restoring square root, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gtse_ratio (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [gtse_pkg::NUM2_W-1:0]  i_num2,
    input  wire logic [gtse_pkg::DEN2_W-1:0]  i_den2,
    output logic                              o_done,
    output logic [gtse_pkg::RATIO_W-1:0]      o_ratio
);
    import gtse_pkg::*;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT
    } t_ustate;

    t_ustate              r_state;
    logic [5:0]           r_cnt;
    logic [DEN2_W-1:0]    r_den;
    logic [DEN2_W-1:0]    r_rem;
    logic [QUO_W-1:0]     r_sr;
    logic [QUO_W-1:0]     r_q;
    logic [RATIO_W+1:0]   r_srem;
    logic [RATIO_W-1:0]   r_root;
    logic                 r_done;

    logic [DEN2_W:0]      w_dt;
    logic                 w_dge;
    logic [DEN2_W-1:0]    n_rem;
    logic [RATIO_W+3:0]   w_st;
    logic [RATIO_W+3:0]   w_trial;
    logic                 w_sge;
    logic [RATIO_W+1:0]   n_srem;
    logic                 w_sat;

    assign w_dt    = {r_rem, r_sr[QUO_W-1]};
    assign w_dge   = w_dt >= {1'b0, r_den};
    assign n_rem   = w_dge ? DEN2_W'(w_dt - {1'b0, r_den}) : w_dt[DEN2_W-1:0];

    assign w_st    = {r_srem, r_q[QUO_W-1:QUO_W-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = w_st >= w_trial;
    assign n_srem  = w_sge ? (RATIO_W+2)'(w_st - w_trial) : w_st[RATIO_W+1:0];

    assign w_sat   = (i_den2 == '0) || ({13'b0, i_num2[NUM2_W-1:16]} >= i_den2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        if (w_sat) begin
                            r_root <= '1;
                            r_done <= 1'b1;
                        end else begin
                            r_den   <= i_den2;
                            r_rem   <= DEN2_W'(i_num2[NUM2_W-1:16]);
                            r_sr    <= {i_num2[15:0], 32'b0};
                            r_q     <= '0;
                            r_cnt   <= '0;
                            r_state <= U_DIV;
                        end
                    end
                end
                U_DIV: begin
                    r_rem <= n_rem;
                    r_sr  <= {r_sr[QUO_W-2:0], 1'b0};
                    r_q   <= {r_q[QUO_W-2:0], w_dge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(QUO_W-1)) begin
                        r_cnt   <= '0;
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_state <= U_SQRT;
                    end
                end
                U_SQRT: begin
                    r_srem <= n_srem;
                    r_root <= {r_root[RATIO_W-2:0], w_sge};
                    r_q    <= {r_q[QUO_W-3:0], 2'b00};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'(RATIO_W-1)) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_ratio = r_root;

endmodule

`default_nettype wire

// ----- src/gtse_dp.sv -----
// ----------------------------------------------------------------------------
// gtse_dp
// datapath: corner table, grid, energy store, triple arithmetic and best
// ----------------------------------------------------------------------------
`default_nettype none

module gtse_dp #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLS    = 16,
    parameter int MAX_CORNERS = 256
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire gtse_pkg::t_cmd                                i_cmd,
    output gtse_pkg::t_sts                                     o_sts,
    input  wire logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]          i_grid_addr,
    input  wire logic [$clog2(MAX_ROWS)-1:0]                   i_walk_row,
    input  wire logic [$clog2(MAX_COLS)-1:0]                   i_walk_col,
    input  wire logic [1:0]                                    i_walk_dir,
    input  wire logic [8:0]                                    i_weight,
    input  wire logic [7:0]                                    i_corner_slot,
    input  wire logic [19:0]                                   i_point_x,
    input  wire logic [19:0]                                   i_point_y,
    input  wire logic [3:0]                                    i_cell_row,
    input  wire logic [3:0]                                    i_cell_col,
    input  wire logic [8:0]                                    i_cell_corner,
    input  wire logic [1:0]                                    i_read_direction,
    output logic [3:0]                                         o_best_col,
    output logic [3:0]                                         o_best_row,
    output logic [1:0]                                         o_best_direction,
    output logic [gtse_pkg::OUT_E_W-1:0]                       o_energy_value
);
    import gtse_pkg::*;

    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int GRID_AW = $clog2(CELLS);
    localparam int CRN_AW  = $clog2(MAX_CORNERS);

    logic [39:0]          r_corner_mem [MAX_CORNERS];
    logic [8:0]           r_grid_mem [CELLS];
    logic [ENERGY_W-1:0]  r_emem [3][CELLS];

    logic [39:0]          r_pt_q;
    logic [8:0]           r_grid_q;
    logic [ENERGY_W-1:0]  r_eq [3];
    logic                 r_rd_ok;
    logic [1:0]           r_rd_dir;

    logic [8:0]           r_cell [3];
    logic [19:0]          r_px [3];
    logic [19:0]          r_py [3];

    logic signed [22:0]   r_nx, r_ny;
    logic signed [20:0]   r_dx, r_dy;
    logic [42:0]          r_nx2, r_ny2;
    logic [39:0]          r_dx2, r_dy2;
    logic [NUM2_W-1:0]    r_num2;
    logic [DEN2_W-1:0]    r_den2;
    logic signed [ENERGY_W-1:0] r_energy;

    logic [RATIO_W-1:0]   r_best_ratio;
    logic [3:0]           r_best_col, r_best_row;
    logic [1:0]           r_best_dir;

    logic [GRID_AW-1:0]   w_in_addr;
    logic                 w_in_ok;
    logic [8:0]           w_rd_cell;
    logic                 w_ratio_done;
    logic [RATIO_W-1:0]   w_ratio;
    logic signed [25:0]   w_rdiff;
    logic [ENERGY_W-1:0]  w_esel;

    function automatic logic is_filled(input logic [8:0] v);
        return !v[8] && (int'(v[7:0]) < MAX_CORNERS);
    endfunction

    assign w_in_addr = GRID_AW'(GRID_AW'(i_cell_row) * GRID_AW'(MAX_COLS)
                                + GRID_AW'(i_cell_col));
    assign w_in_ok   = (int'(i_cell_row) < MAX_ROWS) && (int'(i_cell_col) < MAX_COLS);
    assign w_rd_cell = r_cell[i_cmd.rd_sel];

    // corner table
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_corner && (int'(i_corner_slot) < MAX_CORNERS)) begin
            r_corner_mem[CRN_AW'(i_corner_slot)] <= {i_point_y, i_point_x};
        end
        if (i_cmd.p_rd) begin
            r_pt_q <= r_corner_mem[CRN_AW'(w_rd_cell[7:0])];
        end
    end

    // grid
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cell && w_in_ok) begin
            r_grid_mem[w_in_addr] <= i_cell_corner;
        end
        if (i_cmd.g_rd) begin
            r_grid_q <= r_grid_mem[i_grid_addr];
        end
    end

    // energy store, one bank per direction
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 3; b++) begin
            if (i_cmd.clr_wr) begin
                r_emem[b][i_grid_addr] <= '0;
            end else if (i_cmd.wr && (i_walk_dir == 2'(b))) begin
                r_emem[b][i_grid_addr] <= r_energy;
            end
            if (i_cmd.rd_energy) begin
                r_eq[b] <= r_emem[b][w_in_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_energy) begin
            r_rd_ok  <= w_in_ok && (i_read_direction != 2'd3);
            r_rd_dir <= i_read_direction;
        end
        if (i_cmd.cell_cap) begin
            r_cell[i_cmd.cap_sel] <= r_grid_q;
        end
        if (i_cmd.pt_cap) begin
            r_px[i_cmd.cap_sel] <= r_pt_q[19:0];
            r_py[i_cmd.cap_sel] <= r_pt_q[39:20];
        end
        if (i_cmd.diff) begin
            r_nx <= $signed({3'b0, r_px[0]}) + $signed({3'b0, r_px[2]})
                    - $signed({2'b0, r_px[1], 1'b0});
            r_ny <= $signed({3'b0, r_py[0]}) + $signed({3'b0, r_py[2]})
                    - $signed({2'b0, r_py[1], 1'b0});
            r_dx <= $signed({1'b0, r_px[0]}) - $signed({1'b0, r_px[2]});
            r_dy <= $signed({1'b0, r_py[0]}) - $signed({1'b0, r_py[2]});
        end
        if (i_cmd.square) begin
            r_nx2 <= 43'(r_nx * r_nx);
            r_ny2 <= 43'(r_ny * r_ny);
            r_dx2 <= 40'(r_dx * r_dx);
            r_dy2 <= 40'(r_dy * r_dy);
        end
        if (i_cmd.sum) begin
            r_num2 <= NUM2_W'({1'b0, r_nx2} + {1'b0, r_ny2});
            r_den2 <= DEN2_W'({1'b0, r_dx2} + {1'b0, r_dy2});
        end
        if (i_cmd.mul) begin
            r_energy <= ENERGY_W'(w_rdiff * $signed({1'b0, i_weight}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.best_clr) begin
            r_best_ratio <= '0;
            r_best_col   <= '0;
            r_best_row   <= '0;
            r_best_dir   <= '0;
        end else if (i_cmd.wr && (w_ratio > r_best_ratio)) begin
            r_best_ratio <= w_ratio;
            r_best_col   <= 4'(i_walk_col);
            r_best_row   <= 4'(i_walk_row);
            r_best_dir   <= i_walk_dir;
        end
    end

    assign w_rdiff = $signed({2'b00, w_ratio}) - 26'(ONE_Q16);

    gtse_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ratio_go),
        .i_num2  (r_num2),
        .i_den2  (r_den2),
        .o_done  (w_ratio_done),
        .o_ratio (w_ratio)
    );

    assign w_esel = r_eq[r_rd_dir == 2'd3 ? 2'd0 : r_rd_dir];

    assign o_sts.filled     = is_filled(r_cell[0]) && is_filled(r_cell[1])
                              && is_filled(r_cell[2]);
    assign o_sts.ratio_done = w_ratio_done;

    assign o_best_col       = r_best_col;
    assign o_best_row       = r_best_row;
    assign o_best_direction = r_best_dir;
    assign o_energy_value   = r_rd_ok ? {w_esel[ENERGY_W-1], w_esel} : '0;

endmodule

`default_nettype wire

// ----- src/gtse_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtse_ctrl
// controller: clearing pass, item decode and the triple walk sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module gtse_ctrl #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    input  wire logic [1:0]                           i_in_func,
    output logic                                      o_in_ready,
    input  wire logic                                 i_out_free,
    input  wire logic [4:0]                           i_grid_rows,
    input  wire logic [4:0]                           i_grid_cols,
    input  wire gtse_pkg::t_sts                       i_sts,
    output gtse_pkg::t_cmd                            o_cmd,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      o_grid_addr,
    output logic [$clog2(MAX_ROWS)-1:0]               o_walk_row,
    output logic [$clog2(MAX_COLS)-1:0]               o_walk_col,
    output logic [1:0]                                o_walk_dir
);
    import gtse_pkg::*;

    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int GRID_AW = $clog2(CELLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int LIM_W   = $clog2((MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 32) + 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_POS,
        S_G0, S_G1, S_G2, S_G3, S_CHK,
        S_P0, S_P1, S_P2, S_P3,
        S_DIFF, S_SQ, S_SUM, S_GO, S_WAIT,
        S_MUL, S_WR, S_NEXT, S_DONE
    } t_state;

    t_state             r_state;
    logic [GRID_AW-1:0] r_clr;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [1:0]         r_dir;

    logic               w_accept;
    logic [LIM_W-1:0]   w_nr, w_nc, w_re, w_ce, w_two;
    logic               w_pos_ok;
    logic [GRID_AW-1:0] w_k, w_offr, w_offc, w_taddr;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_nr  = (LIM_W'(i_grid_rows) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                            : LIM_W'(i_grid_rows);
    assign w_nc  = (LIM_W'(i_grid_cols) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                            : LIM_W'(i_grid_cols);
    assign w_re  = LIM_W'(r_row);
    assign w_ce  = LIM_W'(r_col);
    assign w_two = LIM_W'(2);

    always_comb begin
        unique case (r_dir)
            DIR_ROW:  w_pos_ok = (w_re < w_nr) && (w_ce + w_two < w_nc);
            DIR_DIAG: w_pos_ok = (w_re + w_two < w_nr) && (w_ce + w_two < w_nc);
            DIR_COL:  w_pos_ok = (w_re + w_two < w_nr) && (w_ce < w_nc);
            default:  w_pos_ok = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_G1:    w_k = GRID_AW'(1);
            S_G2:    w_k = GRID_AW'(2);
            default: w_k = '0;
        endcase
    end

    assign w_offr  = (r_dir != DIR_ROW) ? w_k : '0;
    assign w_offc  = (r_dir != DIR_COL) ? w_k : '0;
    assign w_taddr = GRID_AW'((GRID_AW'(r_row) + w_offr) * GRID_AW'(MAX_COLS)
                              + GRID_AW'(r_col) + w_offc);
    assign o_grid_addr = (r_state == S_CLEAR) ? r_clr : w_taddr;
    assign o_walk_row  = r_row;
    assign o_walk_col  = r_col;
    assign o_walk_dir  = r_dir;

    always_comb begin
        o_cmd           = '0;
        o_cmd.ld_corner = w_accept && (i_in_func == F_LOAD_CORNER);
        o_cmd.ld_cell   = w_accept && (i_in_func == F_LOAD_CELL);
        o_cmd.best_clr  = w_accept && (i_in_func == F_COMPUTE);
        o_cmd.rd_energy = w_accept && (i_in_func == F_READ);
        unique case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_G0:    o_cmd.g_rd = 1'b1;
            S_G1: begin
                o_cmd.g_rd     = 1'b1;
                o_cmd.cell_cap = 1'b1;
                o_cmd.cap_sel  = 2'd0;
            end
            S_G2: begin
                o_cmd.g_rd     = 1'b1;
                o_cmd.cell_cap = 1'b1;
                o_cmd.cap_sel  = 2'd1;
            end
            S_G3: begin
                o_cmd.cell_cap = 1'b1;
                o_cmd.cap_sel  = 2'd2;
            end
            S_P0: begin
                o_cmd.p_rd   = 1'b1;
                o_cmd.rd_sel = 2'd0;
            end
            S_P1: begin
                o_cmd.p_rd    = 1'b1;
                o_cmd.rd_sel  = 2'd1;
                o_cmd.pt_cap  = 1'b1;
                o_cmd.cap_sel = 2'd0;
            end
            S_P2: begin
                o_cmd.p_rd    = 1'b1;
                o_cmd.rd_sel  = 2'd2;
                o_cmd.pt_cap  = 1'b1;
                o_cmd.cap_sel = 2'd1;
            end
            S_P3: begin
                o_cmd.pt_cap  = 1'b1;
                o_cmd.cap_sel = 2'd2;
            end
            S_DIFF:  o_cmd.diff = 1'b1;
            S_SQ:    o_cmd.square = 1'b1;
            S_SUM:   o_cmd.sum = 1'b1;
            S_GO:    o_cmd.ratio_go = 1'b1;
            S_MUL:   o_cmd.mul = 1'b1;
            S_WR:    o_cmd.wr = 1'b1;
            S_RD: begin
                o_cmd.emit      = i_out_free;
                o_cmd.emit_kind = KIND_ENERGY;
            end
            S_DONE: begin
                o_cmd.emit      = i_out_free;
                o_cmd.emit_kind = KIND_BEST;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_dir   <= DIR_ROW;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + GRID_AW'(1);
                    if (r_clr == GRID_AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_func == F_COMPUTE) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_dir   <= DIR_ROW;
                            r_state <= S_POS;
                        end else if (i_in_func == F_READ) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD:   if (i_out_free) r_state <= S_IDLE;
                S_POS:  r_state <= w_pos_ok ? S_G0 : S_NEXT;
                S_G0:   r_state <= S_G1;
                S_G1:   r_state <= S_G2;
                S_G2:   r_state <= S_G3;
                S_G3:   r_state <= S_CHK;
                S_CHK:  r_state <= i_sts.filled ? S_P0 : S_NEXT;
                S_P0:   r_state <= S_P1;
                S_P1:   r_state <= S_P2;
                S_P2:   r_state <= S_P3;
                S_P3:   r_state <= S_DIFF;
                S_DIFF: r_state <= S_SQ;
                S_SQ:   r_state <= S_SUM;
                S_SUM:  r_state <= S_GO;
                S_GO:   r_state <= S_WAIT;
                S_WAIT: if (i_sts.ratio_done) r_state <= S_MUL;
                S_MUL:  r_state <= S_WR;
                S_WR:   r_state <= S_NEXT;
                S_NEXT: begin
                    r_state <= S_POS;
                    if (r_col == COL_W'(MAX_COLS - 1)) begin
                        r_col <= '0;
                        if (r_row == ROW_W'(MAX_ROWS - 1)) begin
                            r_row <= '0;
                            if (r_dir == DIR_COL) begin
                                r_state <= S_DONE;
                            end else begin
                                r_dir <= r_dir + 2'd1;
                            end
                        end else begin
                            r_row <= r_row + ROW_W'(1);
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                S_DONE: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
